[sv/triangle_span_generator_top_macros.svh]
// Assertion macros for the triangle span generator.
// Used by the top level only.
`ifndef TRIANGLE_SPAN_GENERATOR_TOP_MACROS_SVH
`define TRIANGLE_SPAN_GENERATOR_TOP_MACROS_SVH
// implication checked on every clock, disabled during reset
`define TSG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TSG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/tsg_pkg.sv]
// Package for the triangle span generator: widths, function codes, state type.
// No dependencies.
`default_nettype none
package tsg_pkg;
    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 32;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;
    typedef enum logic [2:0] {
        ST_IDLE, ST_SORT, ST_DIV_L, ST_DIV_S, ST_OUT
    } t_state;
endpackage
`default_nettype wire

[sv/tsg_div.sv]
// Radix-2 restoring signed divider, quotient truncated toward zero.
// Done and the quotient hold after the last step until the next start; no other dependencies.
`default_nettype none
module tsg_div #(
    parameter int NB = 26,
    parameter int DB = 13
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NB-1:0] i_num,
    input  wire logic signed [DB-1:0] i_den,
    output logic                      o_done,
    output logic signed [NB-1:0]      o_quo
);
    localparam int CW = $clog2(NB + 1);
    logic [NB-1:0] r_q, n_q;
    logic [DB:0]   r_rem, n_rem;
    logic [DB-1:0] r_d, n_d;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DB:0]   w_trial;
    logic [DB:0]   w_sh;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_d = r_d; n_neg = r_neg;
        n_cnt = r_cnt; n_busy = r_busy; n_done = r_done;
        w_sh = {r_rem[DB-1:0], r_q[NB-1]};
        w_trial = w_sh - {1'b0, r_d};
        if (i_start) begin
            n_q   = i_num[NB-1] ? NB'(-i_num) : i_num;
            n_d   = i_den[DB-1] ? DB'(-i_den) : i_den;
            n_neg = i_num[NB-1] ^ i_den[DB-1];
            n_rem = '0;
            n_cnt = CW'(NB);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (!w_trial[DB]) begin
                n_rem = w_trial;
                n_q = {r_q[NB-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q = {r_q[NB-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_d <= n_d; r_neg <= n_neg;
    end

    assign o_done = r_done;
    always_comb begin
        if (r_neg) o_quo = -$signed(r_q);
        else       o_quo = $signed(r_q);
    end
endmodule
`default_nettype wire

[sv/triangle_span_generator_top.sv]
// Triangle span generator on tsg_pkg and tsg_div: sort vertices on load, one span per request while rows remain.
// Load: the accept sorts the first vertex pair, then ST_SORT and ST_OUT finish the sort.
// Span: a request runs two passes through the shared radix-2 divider (ST_DIV_L, then ST_DIV_S)
// before m_axis_tvalid; no new request is taken until the span is registered.
// A finished span holds in the divider until the output register is free.
// Synchronous active-low reset returns to idle with no triangle loaded.
`default_nettype none
`include "triangle_span_generator_top_macros.svh"
module triangle_span_generator_top #(
    parameter int COORD_BITS = tsg_pkg::COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // func (tuser)
    input  wire logic s_axis_tuser,
    // a_x, a_y, b_x, b_y, c_x, c_y, fill_color, zero pad
    input  wire logic [((6*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // span_last
    output logic      m_axis_tlast,
    // span_row, span_left, span_right, span_color, zero pad
    output logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_axis_tdata
);
    localparam int CB = COORD_BITS;
    localparam int NB = 2*CB + 2;
    localparam int DB = CB + 1;
    localparam int OW = ((3*CB+32+7)/8)*8;
    typedef logic signed [CB-1:0] t_c;

    tsg_pkg::t_state r_st, n_st;
    t_c r_tx, r_ty, r_mx, r_my, r_bx, r_by, r_row, r_xl;
    logic [31:0] r_col;
    logic r_busy;
    logic r_ov, n_ov;
    logic [OW-1:0] r_od;
    logic r_ol;

    t_c ax, ay, bx, by, cx, cy, t0x, t0y, t1x, t1y, s0x, s0y, s1x, s1y;
    logic acc, dstart, ddone, w_fin;
    logic signed [NB-1:0] num, quo;
    logic signed [DB-1:0] den;
    logic signed [CB:0] dxl, offl, hl, dxs, offs, hs, mul_a, mul_b;
    logic lower, last;
    t_c xbase, xl, xs, lo, hi;

    assign s_axis_tready = (r_st == tsg_pkg::ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign ax = s_axis_tdata[CB-1:0];
    assign ay = s_axis_tdata[2*CB-1:CB];
    assign bx = s_axis_tdata[3*CB-1:2*CB];
    assign by = s_axis_tdata[4*CB-1:3*CB];
    assign cx = s_axis_tdata[5*CB-1:4*CB];
    assign cy = s_axis_tdata[6*CB-1:5*CB];

    always_comb begin
        if (ay > by) begin t0x = bx; t0y = by; t1x = ax; t1y = ay; end
        else begin t0x = ax; t0y = ay; t1x = bx; t1y = by; end
        if (r_my > r_by) begin s0x = r_bx; s0y = r_by; s1x = r_mx; s1y = r_my; end
        else begin s0x = r_mx; s0y = r_my; s1x = r_bx; s1y = r_by; end
    end

    assign lower = (r_row > r_my) || (r_my == r_ty);
    assign dxl  = (CB+1)'(r_bx) - (CB+1)'(r_tx);
    assign offl = (CB+1)'(r_row) - (CB+1)'(r_ty);
    assign hl   = (CB+1)'(r_by) - (CB+1)'(r_ty);
    always_comb begin
        if (lower) begin
            dxs = (CB+1)'(r_bx) - (CB+1)'(r_mx);
            offs = (CB+1)'(r_row) - (CB+1)'(r_my);
            hs = (CB+1)'(r_by) - (CB+1)'(r_my);
        end else begin
            dxs = (CB+1)'(r_mx) - (CB+1)'(r_tx);
            offs = offl;
            hs = (CB+1)'(r_my) - (CB+1)'(r_ty);
        end
    end

    always_comb begin
        dstart = 1'b0;
        mul_a = dxl;
        mul_b = offl;
        den = hl;
        if (r_st == tsg_pkg::ST_IDLE && acc && s_axis_tuser == tsg_pkg::FUNC_NEXT && r_busy)
            dstart = 1'b1;
        if (r_st == tsg_pkg::ST_DIV_L && ddone) begin
            dstart = 1'b1; mul_a = dxs; mul_b = offs; den = hs;
        end
    end
    assign num = NB'(mul_a) * NB'(mul_b);

    tsg_div #(.NB(NB), .DB(DB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dstart),
        .i_num(num), .i_den(den), .o_done(ddone), .o_quo(quo)
    );

    assign xbase = lower ? r_mx : r_tx;
    assign xl = r_xl;
    assign xs = t_c'(xbase + quo[CB-1:0]);
    assign lo = (xl < xs) ? xl : xs;
    assign hi = (xl < xs) ? xs : xl;
    assign last = (r_row >= r_by);
    assign w_fin = (r_st == tsg_pkg::ST_DIV_S) && ddone && (!r_ov || m_axis_tready);
    assign n_ov = w_fin ? 1'b1 : (m_axis_tready ? 1'b0 : r_ov);

    always_comb begin
        n_st = r_st;
        case (r_st)
            tsg_pkg::ST_IDLE:
                if (acc) begin
                    if (s_axis_tuser == tsg_pkg::FUNC_LOAD) n_st = tsg_pkg::ST_SORT;
                    else if (r_busy) n_st = tsg_pkg::ST_DIV_L;
                end
            tsg_pkg::ST_SORT: n_st = tsg_pkg::ST_OUT;
            tsg_pkg::ST_DIV_L: if (ddone) n_st = tsg_pkg::ST_DIV_S;
            tsg_pkg::ST_DIV_S: if (w_fin) n_st = tsg_pkg::ST_IDLE;
            tsg_pkg::ST_OUT: n_st = tsg_pkg::ST_IDLE;
            default: n_st = tsg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tsg_pkg::ST_IDLE;
            r_busy <= 1'b0;
            r_ov <= 1'b0;
            r_tx <= '0; r_ty <= '0; r_mx <= '0; r_my <= '0;
            r_bx <= '0; r_by <= '0; r_row <= '0; r_col <= '0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            case (r_st)
                tsg_pkg::ST_IDLE:
                    if (acc && s_axis_tuser == tsg_pkg::FUNC_LOAD) begin
                        r_tx <= t0x; r_ty <= t0y; r_mx <= t1x; r_my <= t1y;
                        r_bx <= cx; r_by <= cy;
                        r_col <= s_axis_tdata[6*CB+31:6*CB];
                    end
                tsg_pkg::ST_SORT: begin
                    r_mx <= s0x; r_my <= s0y; r_bx <= s1x; r_by <= s1y;
                end
                tsg_pkg::ST_OUT: begin
                    if (r_ty > s0y) begin
                        r_tx <= s0x; r_ty <= s0y; r_mx <= r_tx; r_my <= r_ty;
                        r_row <= s0y; r_busy <= (s0y != r_by);
                    end else begin
                        r_row <= r_ty; r_busy <= (r_ty != r_by);
                    end
                end
                tsg_pkg::ST_DIV_S:
                    if (w_fin) begin
                        if (last) r_busy <= 1'b0;
                        else r_row <= r_row + 1'b1;
                    end
                default: ;
            endcase
        end
        if (r_st == tsg_pkg::ST_DIV_L && ddone)
            r_xl <= (hl <= 0) ? r_tx : t_c'(r_tx + quo[CB-1:0]);
        if (w_fin) begin
            r_od <= OW'({r_col, hi, lo, r_row});
            r_ol <= last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;
    assign m_axis_tlast = r_ol;

    `TSG_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_st == tsg_pkg::ST_IDLE)
    `TSG_ASSERT_IMP(a_out_idle, i_clk, i_rst_n, r_st != tsg_pkg::ST_IDLE, !s_axis_tready)
    `TSG_ASSERT_NXT(a_span_done, i_clk, i_rst_n, w_fin, m_axis_tvalid)
    `TSG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for triangle_span_generator_top: loads triangles and pulls spans over the
// stream ports, checking every span against a behavioral scanline predictor.
// Depends on tsg_pkg and the RTL of triangle_span_generator_top.
`timescale 1ns / 100ps
module testbench;

    localparam int CB = 12;
    localparam int IN_W = ((6*CB+32+7)/8)*8;
    localparam int OUT_W = ((3*CB+32+7)/8)*8;

    typedef struct packed {
        logic          func;
        logic [IN_W-1:0] data;
    } tri_cmd_t;

    typedef struct packed {
        logic [CB-1:0] row;
        logic [CB-1:0] left;
        logic [CB-1:0] right;
        logic [31:0]   color;
        logic          last;
    } span_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic s_axis_tuser = 1'b0;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic m_axis_tlast;
    logic [OUT_W-1:0] m_axis_tdata;

    triangle_span_generator_top #(.COORD_BITS(CB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tri_cmd_t pending_cmds[$];
    span_t expected_spans[$];
    int error_count = 0;
    bit calm = 0;
    int src_gap = 0;
    int sink_gap = 0;

    // predictor state
    int top_x, top_y, mid_x, mid_y, bot_x, bot_y, cur_row;
    logic [31:0] held_color;
    bit busy;

    function automatic int sx(logic [CB-1:0] v);
        return int'($signed(v));
    endfunction

    function automatic int edge_at(int x0, int dx, int off, int h);
        if (h <= 0) return x0;
        return x0 + (dx * off) / h;
    endfunction

    function automatic void predict_span(tri_cmd_t c);
        int ax, ay, bx, by, cx, cy, t, xl, xs, lo, hi;
        bit lower, last;
        span_t s;
        if (c.func == tsg_pkg::FUNC_LOAD) begin
            ax = sx(c.data[0*CB +: CB]); ay = sx(c.data[1*CB +: CB]);
            bx = sx(c.data[2*CB +: CB]); by = sx(c.data[3*CB +: CB]);
            cx = sx(c.data[4*CB +: CB]); cy = sx(c.data[5*CB +: CB]);
            if (ay > by) begin t = ax; ax = bx; bx = t; t = ay; ay = by; by = t; end
            if (by > cy) begin t = bx; bx = cx; cx = t; t = by; by = cy; cy = t; end
            if (ay > by) begin t = ax; ax = bx; bx = t; t = ay; ay = by; by = t; end
            top_x = ax; top_y = ay; mid_x = bx; mid_y = by; bot_x = cx; bot_y = cy;
            held_color = c.data[6*CB +: 32];
            cur_row = ay;
            busy = (ay != cy);
            return;
        end
        if (!busy) return;
        lower = (cur_row > mid_y) || (mid_y == top_y);
        xl = edge_at(top_x, bot_x - top_x, cur_row - top_y, bot_y - top_y);
        if (lower) xs = edge_at(mid_x, bot_x - mid_x, cur_row - mid_y, bot_y - mid_y);
        else xs = edge_at(top_x, mid_x - top_x, cur_row - top_y, mid_y - top_y);
        lo = xl < xs ? xl : xs;
        hi = xl < xs ? xs : xl;
        last = (cur_row >= bot_y);
        s.row = cur_row[CB-1:0];
        s.left = lo[CB-1:0];
        s.right = hi[CB-1:0];
        s.color = held_color;
        s.last = last;
        expected_spans.push_back(s);
        if (last) busy = 0;
        else cur_row = cur_row + 1;
    endfunction

    function automatic tri_cmd_t make_load(int ax, int ay, int bx, int by, int cx, int cy,
                                           logic [31:0] col);
        tri_cmd_t c;
        c.func = tsg_pkg::FUNC_LOAD;
        c.data = '0;
        c.data[0*CB +: CB] = ax[CB-1:0]; c.data[1*CB +: CB] = ay[CB-1:0];
        c.data[2*CB +: CB] = bx[CB-1:0]; c.data[3*CB +: CB] = by[CB-1:0];
        c.data[4*CB +: CB] = cx[CB-1:0]; c.data[5*CB +: CB] = cy[CB-1:0];
        c.data[6*CB +: 32] = col;
        return c;
    endfunction

    function automatic tri_cmd_t make_next();
        tri_cmd_t c;
        c.func = tsg_pkg::FUNC_NEXT;
        c.data = IN_W'({$urandom, $urandom, $urandom, $urandom});
        return c;
    endfunction

    function automatic int rnd_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_span({s_axis_tuser, s_axis_tdata});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        src_gap <= $urandom_range(1, 6);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        {s_axis_tuser, s_axis_tdata} <= pending_cmds.pop_front();
                        s_axis_tvalid <= 1'b1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        span_t got, exp_s;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.row = m_axis_tdata[0 +: CB];
                got.left = m_axis_tdata[CB +: CB];
                got.right = m_axis_tdata[2*CB +: CB];
                got.color = m_axis_tdata[3*CB +: 32];
                got.last = m_axis_tlast;
                if (expected_spans.size() == 0) begin
                    $error("unexpected span row=%0d", $signed(got.row));
                    error_count++;
                end else begin
                    exp_s = expected_spans.pop_front();
                    if (got.row !== exp_s.row) begin
                        $error("span_row exp %0d got %0d", $signed(exp_s.row), $signed(got.row));
                        error_count++;
                    end
                    if (got.left !== exp_s.left) begin
                        $error("span_left exp %0d got %0d", $signed(exp_s.left),
                               $signed(got.left));
                        error_count++;
                    end
                    if (got.right !== exp_s.right) begin
                        $error("span_right exp %0d got %0d", $signed(exp_s.right),
                               $signed(got.right));
                        error_count++;
                    end
                    if (got.color !== exp_s.color) begin
                        $error("span_color exp %h got %h", exp_s.color, got.color);
                        error_count++;
                    end
                    if (got.last !== exp_s.last) begin
                        $error("span_last exp %0b got %0b", exp_s.last, got.last);
                        error_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int n, h, rows, x0, y0, k;
        tri_cmd_t c;
        // directed: idle next, extremes, flat top/bottom, zero height, load while busy
        pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_load(-2048, 2047, 2047, 2046, 0, 2045, 32'hFFFF_FFFF));
        for (k = 0; k < 4; k++) pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_load(-2048, -2048, 2047, -2048, 5, -2045, 32'h0));
        for (k = 0; k < 5; k++) pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_load(3, 10, -2048, 13, 2047, 13, 32'hA5A5_5A5A));
        for (k = 0; k < 4; k++) pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_load(7, 100, -7, 100, 2047, 100, 32'h1234_5678));
        pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_load(0, 0, 40, 20, -40, 9, 32'h5555_AAAA));
        pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_next());
        pending_cmds.push_back(make_load(-2048, -2048, 2047, 2047, -2048, 2047, 32'hDEAD_BEEF));
        pending_cmds.push_back(make_next());
        // random: mostly small triangles pulled to the end, some cut short or noise
        n = 0;
        while (n < 750) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_cmds.push_back(make_next());
                n++;
                continue;
            end
            h = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 19) == 0) begin
                c = make_load(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                              rnd_coord(), rnd_coord(), $urandom);
                rows = 3;
            end else begin
                x0 = rnd_coord();
                y0 = $urandom_range(0, 4095 - h) - 2048;
                c = make_load(rnd_coord(), y0 + $urandom_range(0, h), rnd_coord(), y0,
                              rnd_coord(), y0 + h, $urandom);
                rows = h + 1;
                if (x0 < 0 && $urandom_range(0, 3) == 0) rows = $urandom_range(0, h);
            end
            pending_cmds.push_back(c);
            for (k = 0; k < rows; k++) pending_cmds.push_back(make_next());
            n += rows + 1;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() < 40);
        calm = 1;
        wait (pending_cmds.size() == 0 && !s_axis_tvalid && expected_spans.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_spans.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
